// ===== design/skic_pkg.sv =====
package skic_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int WID_W = 12;
    localparam int HGT_W = 13;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = 12;
    localparam int PEND_W = 14;
    localparam int ADDR_W = 3;

    localparam logic [WID_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [WID_W-1:0] WIDTH_MAX_V  = 12'd2048;
    localparam logic [HGT_W-1:0] HEIGHT_MAX_V = 13'd4096;
    localparam logic [HGT_W-1:0] DIM_MIN      = 13'd5;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [0:0] MODE_PIXEL = 1'b0;

    // Reciprocals: (x * RECIP) >> SHIFT is exact over the value ranges used.
    localparam logic [10:0] RECIP5       = 11'd1639;
    localparam int          RECIP5_SHIFT = 13;
    localparam logic [26:0] GAUSS_RECIP  = 27'd70368745;
    localparam int          GAUSS_SHIFT  = 44;
    localparam logic [25:0] GAUSS_SAT    = 26'd64000000;

    localparam logic [16:0] GAUSS_W [5][5] = '{
        '{17'd120,  17'd1253,  17'd2736,  17'd1253,  17'd120},
        '{17'd1253, 17'd13054, 17'd28514, 17'd13054, 17'd1253},
        '{17'd2736, 17'd28514, 17'd62279, 17'd28514, 17'd2736},
        '{17'd1253, 17'd13054, 17'd28514, 17'd13054, 17'd1253},
        '{17'd120,  17'd1253,  17'd2736,  17'd1253,  17'd120}
    };

    typedef struct packed {
        logic [7:0]       pixel;
        logic [COL_W-1:0] col;
        logic             emit;
        logic             v3;
        logic             v5;
        logic             fe;
    } skic_item_t;

    function automatic logic [7:0] clamp_byte(input logic signed [12:0] v);
        logic [7:0] r;
        if (v < 0)
        begin
            r = 8'd0;
        end
        else if (v > 13'sd255)
        begin
            r = 8'd255;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

// ===== design/skic_line_mem.sv =====
module skic_line_mem
    import skic_pkg::*;
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    output logic [31:0]      rd_data,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  logic [31:0]      wr_data
);

    // Four previous rows per column, newest row in the low byte.
    logic [31:0] mem [MAX_WIDTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/skic_ctrl.sv =====
module skic_ctrl
    import skic_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             restart,
    input  logic             en,
    input  logic             accept,
    input  logic             mode,
    input  logic [7:0]       pixel,
    input  logic [WID_W-1:0] width,
    input  logic [HGT_W-1:0] height,
    output logic             rd_en,
    output logic [COL_W-1:0] rd_addr,
    output logic             s1_valid,
    output skic_item_t       s1_item
);

    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [HGT_W-1:0]  in_row_reg, in_row_next;
    logic              in_done_reg, in_done_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [COL_W-1:0]  scol_reg, scol_next;
    logic              s1_valid_reg;
    skic_item_t        s1_item_reg;

    logic              take;
    logic              emit;
    logic [PEND_W-1:0] pend_inc;
    logic [PEND_W-1:0] lead;
    logic [WID_W-1:0]  col1, col2, col3, in1, s1c;
    logic [HGT_W-1:0]  row1, row2, row3, inr1;
    logic              v3, v5, fe;

    always_comb
    begin
        take     = accept && (in_done_reg || mode == MODE_PIXEL);
        pend_inc = pend_reg + 1'b1;
        lead     = {1'b0, width, 1'b0} + PEND_W'(3);
        emit     = in_done_reg || (pend_inc >= lead);

        col1 = {1'b0, out_col_reg} + 1'b1;
        col2 = {1'b0, out_col_reg} + WID_W'(2);
        col3 = {1'b0, out_col_reg} + WID_W'(3);
        row1 = {1'b0, out_row_reg} + 1'b1;
        row2 = {1'b0, out_row_reg} + HGT_W'(2);
        row3 = {1'b0, out_row_reg} + HGT_W'(3);
        in1  = {1'b0, in_col_reg} + 1'b1;
        inr1 = in_row_reg + 1'b1;
        s1c  = {1'b0, scol_reg} + 1'b1;

        v3 = (out_row_reg != '0) && (row2 <= height) && (out_col_reg != '0) && (col2 <= width);
        v5 = (out_row_reg >= ROW_W'(2)) && (row3 <= height)
             && (out_col_reg >= COL_W'(2)) && (col3 <= width);
        fe = (row1 == height) && (col1 == width);

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        scol_next    = scol_reg;

        if (take)
        begin
            scol_next = (s1c >= width) ? '0 : s1c[COL_W-1:0];
            if (!in_done_reg)
            begin
                pend_next = emit ? pend_reg : pend_inc;
                if (in1 >= width)
                begin
                    in_col_next = '0;
                    in_row_next = inr1;
                    if (inr1 >= height)
                    begin
                        in_done_next = 1'b1;
                    end
                end
                else
                begin
                    in_col_next = in1[COL_W-1:0];
                end
            end
            if (emit)
            begin
                if (col1 >= width)
                begin
                    out_col_next = '0;
                    out_row_next = row1[ROW_W-1:0];
                end
                else
                begin
                    out_col_next = col1[COL_W-1:0];
                end
            end
            if (emit && fe)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                in_done_next = 1'b0;
                out_col_next = '0;
                out_row_next = '0;
                pend_next    = '0;
                scol_next    = '0;
            end
        end
        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            in_done_next = 1'b0;
            out_col_next = '0;
            out_row_next = '0;
            pend_next    = '0;
            scol_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_done_reg  <= 1'b0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            pend_reg     <= '0;
            scol_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_done_reg <= in_done_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
            scol_reg    <= scol_next;
            if (en)
            begin
                s1_valid_reg <= take;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg.pixel <= pixel;
            s1_item_reg.col   <= scol_reg;
            s1_item_reg.emit  <= emit;
            s1_item_reg.v3    <= v3;
            s1_item_reg.v5    <= v5;
            s1_item_reg.fe    <= fe;
        end
    end

    assign rd_en    = take;
    assign rd_addr  = scol_reg;
    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

endmodule

// ===== design/skic_kernels.sv =====
module skic_kernels
    import skic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        s1_valid,
    input  skic_item_t  s1_item,
    input  logic [31:0] s1_rdata,
    output logic        wr_en,
    output logic [COL_W-1:0] wr_addr,
    output logic [31:0] wr_data,
    output logic        s4_valid,
    output skic_item_t  s4_item,
    output logic [7:0]  s4_cross,
    output logic [7:0]  s4_diag,
    output logic [7:0]  s4_lap,
    output logic [7:0]  s4_sharp,
    output logic [7:0]  s4_emb,
    output logic [25:0] s4_gsum
);

    logic [7:0]  win_reg [5][5];
    logic [7:0]  col_new [5];
    logic        s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    skic_item_t  s2_item_reg, s3_item_reg, s4_item_reg;

    logic [23:0] prod_reg [5][5];
    logic [10:0] csum_reg, dsum_reg;
    logic signed [12:0] lap_reg, emb_reg;
    logic [7:0]  ctr_reg;

    logic [24:0] rsum_reg [5];
    logic [7:0]  cross_reg, diag_reg, lapc_reg, sharp_reg, embc_reg;

    logic [25:0] gsum_reg;
    logic [7:0]  cross4_reg, diag4_reg, lap4_reg, sharp4_reg, emb4_reg;

    logic [10:0] csum_c, dsum_c, nsum_c;
    logic signed [12:0] emb_c, sharp_c;
    logic [24:0] rsum_c [5];
    logic [21:0] cq, dq;

    always_comb
    begin
        col_new[4] = s1_item.pixel;
        col_new[3] = s1_rdata[7:0];
        col_new[2] = s1_rdata[15:8];
        col_new[1] = s1_rdata[23:16];
        col_new[0] = s1_rdata[31:24];
    end

    assign wr_en   = en && s1_valid;
    assign wr_addr = s1_item.col;
    assign wr_data = {s1_rdata[23:0], s1_item.pixel};

    always_comb
    begin
        csum_c = 11'(win_reg[1][2]) + 11'(win_reg[3][2]) + 11'(win_reg[2][1])
                 + 11'(win_reg[2][3]) + 11'(win_reg[2][2]);
        dsum_c = 11'(win_reg[0][0]) + 11'(win_reg[1][1]) + 11'(win_reg[2][2])
                 + 11'(win_reg[3][3]) + 11'(win_reg[4][4]);
        nsum_c = 11'(win_reg[1][1]) + 11'(win_reg[1][2]) + 11'(win_reg[1][3])
                 + 11'(win_reg[2][1]) + 11'(win_reg[2][3])
                 + 11'(win_reg[3][1]) + 11'(win_reg[3][2]) + 11'(win_reg[3][3]);
        emb_c  = $signed(13'(win_reg[2][3])) + $signed(13'(win_reg[3][2]))
                 + $signed(13'(win_reg[3][3])) - $signed(13'(win_reg[1][1]))
                 - $signed(13'(win_reg[1][2])) - $signed(13'(win_reg[2][1]));
        for (int i = 0; i < 5; i++)
        begin
            rsum_c[i] = 25'(prod_reg[i][0]) + 25'(prod_reg[i][1]) + 25'(prod_reg[i][2])
                        + 25'(prod_reg[i][3]) + 25'(prod_reg[i][4]);
        end
        cq      = 22'(csum_reg) * 22'(RECIP5);
        dq      = 22'(dsum_reg) * 22'(RECIP5);
        sharp_c = lap_reg + $signed(13'(ctr_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (s1_valid)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        win_reg[i][j] <= win_reg[i][j+1];
                    end
                    win_reg[i][4] <= col_new[i];
                end
                s2_item_reg <= s1_item;
            end

            for (int i = 0; i < 5; i++)
            begin
                for (int j = 0; j < 5; j++)
                begin
                    prod_reg[i][j] <= 24'(GAUSS_W[i][j]) * 24'(win_reg[i][j]);
                end
            end
            csum_reg    <= csum_c;
            dsum_reg    <= dsum_c;
            ctr_reg     <= win_reg[2][2];
            lap_reg     <= $signed({2'b00, win_reg[2][2], 3'b000}) - $signed({2'b00, nsum_c});
            emb_reg     <= emb_c;
            s3_item_reg <= s2_item_reg;

            rsum_reg    <= rsum_c;
            cross_reg   <= cq[RECIP5_SHIFT+7:RECIP5_SHIFT];
            diag_reg    <= dq[RECIP5_SHIFT+7:RECIP5_SHIFT];
            lapc_reg    <= clamp_byte(lap_reg);
            sharp_reg   <= clamp_byte(sharp_c);
            embc_reg    <= clamp_byte(emb_reg);
            s4_item_reg <= s3_item_reg;

            gsum_reg    <= 26'(rsum_reg[0]) + 26'(rsum_reg[1]) + 26'(rsum_reg[2])
                           + 26'(rsum_reg[3]) + 26'(rsum_reg[4]);
            cross4_reg  <= cross_reg;
            diag4_reg   <= diag_reg;
            lap4_reg    <= lapc_reg;
            sharp4_reg  <= sharp_reg;
            emb4_reg    <= embc_reg;
        end
    end

    // The last stage carries the item tag and its valid flag alongside the
    // Gaussian sum and the finished bytes.
    skic_item_t s5_tag;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_tag <= s4_item_reg;
        end
    end

    assign s4_valid = s5_valid_reg;
    assign s4_item  = s5_tag;
    assign s4_cross = cross4_reg;
    assign s4_diag  = diag4_reg;
    assign s4_lap   = lap4_reg;
    assign s4_sharp = sharp4_reg;
    assign s4_emb   = emb4_reg;
    assign s4_gsum  = gsum_reg;

endmodule

// ===== design/six_kernel_image_convolution.sv =====
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    mode, pixel
// output    out        out_valid / out_ready  six filtered bytes, frame_end
// config    in         APB psel / penable     image_width (0x0), image_height (0x4)
//
// One transaction is taken per clock unless stalled; a pixel's result follows the
// transaction completing its window through a line-store read and four stages.
// The line store is a single 32-bit wide memory holding four previous rows per column,
// read and written back once per transaction; one read port and one write port set
// the rate of one transaction per cycle while the pipeline is not stalled.
// Reset clears counters and valid flags; the line store needs no clearing.
// The whole pipeline advances only while the output register is empty or being taken.
module six_kernel_image_convolution
    import skic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              mode,
    input  logic [7:0]        pixel,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        cross_mean,
    output logic [7:0]        diagonal_mean,
    output logic [7:0]        laplacian_edge,
    output logic [7:0]        sharpened,
    output logic [7:0]        embossed,
    output logic [7:0]        gaussian_blur,
    output logic              frame_end
);

    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic             cfg_we;
    logic [WID_W-1:0] wdata_w;
    logic [HGT_W-1:0] wdata_h;

    logic             en;
    logic             accept;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic [31:0]      rd_data;
    logic             s1_valid;
    skic_item_t       s1_item;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic             s4_valid;
    skic_item_t       s4_item;
    logic [7:0]       s4_cross, s4_diag, s4_lap, s4_sharp, s4_emb;
    logic [25:0]      s4_gsum;
    logic [52:0]      gprod;
    logic [7:0]       gq;

    logic             out_valid_reg;
    logic [7:0]       cross_reg, diag_reg, lap_reg, sharp_reg, emb_reg, gauss_reg;
    logic             fe_reg;

    // Configuration: each write clamps the dimension into range and restarts the frame.
    assign cfg_we  = psel && penable && pwrite;
    assign wdata_w = pwdata[WID_W-1:0];
    assign wdata_h = pwdata[HGT_W-1:0];
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_HEIGHT) ? 32'(height_reg) : 32'(width_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_WIDTH)
            begin
                if (wdata_w < DIM_MIN[WID_W-1:0])
                begin
                    width_reg <= DIM_MIN[WID_W-1:0];
                end
                else if (wdata_w > WIDTH_MAX_V)
                begin
                    width_reg <= WIDTH_MAX_V;
                end
                else
                begin
                    width_reg <= wdata_w;
                end
            end
            else
            begin
                if (wdata_h < DIM_MIN)
                begin
                    height_reg <= DIM_MIN;
                end
                else if (wdata_h > HEIGHT_MAX_V)
                begin
                    height_reg <= HEIGHT_MAX_V;
                end
                else
                begin
                    height_reg <= wdata_h;
                end
            end
        end
    end

    // The pipeline stalls as a whole only when a finished result is not being taken.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && en;

    skic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (cfg_we),
        .en       (en),
        .accept   (accept),
        .mode     (mode),
        .pixel    (pixel),
        .width    (width_reg),
        .height   (height_reg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    skic_line_mem u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    skic_kernels u_kernels (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .s1_valid (s1_valid),
        .s1_item  (s1_item),
        .s1_rdata (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .s4_valid (s4_valid),
        .s4_item  (s4_item),
        .s4_cross (s4_cross),
        .s4_diag  (s4_diag),
        .s4_lap   (s4_lap),
        .s4_sharp (s4_sharp),
        .s4_emb   (s4_emb),
        .s4_gsum  (s4_gsum)
    );

    // Gaussian division by a reciprocal; sums at or above 256 times the divisor saturate.
    assign gprod = 53'(s4_gsum) * 53'(GAUSS_RECIP);
    assign gq    = (s4_gsum >= GAUSS_SAT) ? 8'd255 : gprod[GAUSS_SHIFT+7:GAUSS_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= s4_valid && s4_item.emit;
        end
    end

    // Results whose window leaves the image are forced to zero.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cross_reg <= s4_item.v3 ? s4_cross : 8'd0;
            lap_reg   <= s4_item.v3 ? s4_lap : 8'd0;
            sharp_reg <= s4_item.v3 ? s4_sharp : 8'd0;
            emb_reg   <= s4_item.v3 ? s4_emb : 8'd0;
            diag_reg  <= s4_item.v5 ? s4_diag : 8'd0;
            gauss_reg <= s4_item.v5 ? gq : 8'd0;
            fe_reg    <= s4_item.fe;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cross_mean     = cross_reg;
    assign diagonal_mean  = diag_reg;
    assign laplacian_edge = lap_reg;
    assign sharpened      = sharp_reg;
    assign embossed       = emb_reg;
    assign gaussian_blur  = gauss_reg;
    assign frame_end      = fe_reg;

endmodule
